// File: sv/rcdf_pkg.sv
// rcdf_pkg: shared types and constants for the recent code duplicate filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rcdf_pkg;

    // Field widths
    localparam int CODE_W  = 32;
    localparam int STAMP_W = 32;
    localparam int SLOT_W  = 4;
    localparam int OUT_W   = 8;

    // Defaults
    localparam int             ENTRIES_DEF  = 12;
    localparam logic [31:0]    WINDOW_RESET = 32'd3000;

    // Input action codes
    localparam logic ACT_CHECK = 1'b0;
    localparam logic ACT_STORE = 1'b1;

    // One table entry
    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    // Sequencer control toward the scan unit
    typedef struct packed {
        logic scan_en;
        logic first;
    } scan_ctl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_FINISH
    } state_t;

endpackage

// File: sv/recent_code_duplicate_filter_unit.sv
// recent_code_duplicate_filter_unit: top level, ring of entry cells, scan unit, sequencer.
// Depends on rcdf_pkg, rcdf_cell, rcdf_scan.
`timescale 1ns / 1ps

// Channel     Dir   Width  Contents
// s_axis      in    64+1   tdata: code_value, now_ms; tuser: action
// m_axis      out   8      tdata: is_duplicate, slot_written
// window_wr   in    32     duplicate_window_ms write
//
// A check beat rotates the ring once past a single comparator, and a store beat
// rotates it a second time to drop the new entry into the oldest slot.
// Reset clears the table to zero and sets the window to 3000 ms.
// One beat is in work at a time; a result held by m_axis_tready stalls only the
// final step, and a new input beat is taken as soon as the result is registered.

module recent_code_duplicate_filter_unit #(
    parameter int ENTRIES = rcdf_pkg::ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] code_value, [63:32] now_ms
    input  logic        s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] is_duplicate, [4:1] slot_written, [7:5] zero
    input  logic        window_wr_en,
    input  logic [31:0] window_wr_data
);
    import rcdf_pkg::*;

    localparam int               IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST  = IDX_W'(ENTRIES - 1);

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    step_reg, step_next;
    logic                act_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [STAMP_W-1:0]  now_reg;
    logic [31:0]         window_reg;
    logic                m_valid_reg;
    logic [OUT_W-1:0]    m_data_reg;

    logic                shift_en;
    logic                ld_in;
    logic                ld_out;
    logic                out_free;
    scan_ctl_t           ctl;
    logic                hit;
    logic [IDX_W-1:0]    best_idx;
    logic [SLOT_W-1:0]   slot_out;
    entry_t              ring_in  [ENTRIES];
    entry_t              ring_out [ENTRIES];
    entry_t              new_entry;

    // Ring of cells rotating toward index 0; cell 0 holds entry "step"
    assign new_entry.code  = code_reg;
    assign new_entry.stamp = now_reg;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            if (gi == ENTRIES - 1)
            begin : g_tail
                // Second pass of a store replaces the oldest entry as it wraps
                assign ring_in[gi] = (state_reg == S_WRITE && step_reg == best_idx)
                                     ? new_entry : ring_out[0];
            end
            else
            begin : g_body
                assign ring_in[gi] = ring_out[gi + 1];
            end

            rcdf_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .din      (ring_in[gi]),
                .dout     (ring_out[gi])
            );
        end
    endgenerate

    // Comparator at the ring head
    assign ctl.scan_en = (state_reg == S_SCAN);
    assign ctl.first   = (step_reg == '0);

    rcdf_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .step     (step_reg),
        .head     (ring_out[0]),
        .code     (code_reg),
        .now      (now_reg),
        .window   (window_reg),
        .hit      (hit),
        .best_idx (best_idx)
    );

    // Sequencer
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        shift_en   = 1'b0;
        ld_in      = 1'b0;
        ld_out     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    ld_in      = 1'b1;
                    step_next  = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                shift_en = 1'b1;
                if (step_reg == LAST)
                begin
                    step_next  = '0;
                    state_next = (act_reg == ACT_STORE) ? S_WRITE : S_FINISH;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_WRITE:
            begin
                shift_en = 1'b1;
                if (step_reg == LAST)
                begin
                    step_next  = '0;
                    state_next = S_FINISH;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    ld_out     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Input beat capture
    always_ff @(posedge clk)
    begin
        if (ld_in)
        begin
            act_reg  <= s_axis_tuser;
            code_reg <= s_axis_tdata[31:0];
            now_reg  <= s_axis_tdata[63:32];
        end
    end

    // Window register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else if (window_wr_en)
        begin
            window_reg <= window_wr_data;
        end
    end

    // Output register
    assign slot_out = SLOT_W'(best_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (ld_out)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_out)
        begin
            if (act_reg == ACT_STORE)
            begin
                m_data_reg <= {3'b000, slot_out, 1'b0};
            end
            else
            begin
                m_data_reg <= {3'b000, {SLOT_W{1'b0}}, hit};
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// File: sv/rcdf_cell.sv
// rcdf_cell: one table entry of the rotating ring (code and timestamp).
// Depends on rcdf_pkg.
`timescale 1ns / 1ps

module rcdf_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift_en,
    input  rcdf_pkg::entry_t din,
    output rcdf_pkg::entry_t dout
);
    import rcdf_pkg::*;

    entry_t entry_reg;

    // Take the neighbor's entry on every shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (shift_en)
        begin
            entry_reg <= din;
        end
    end

    assign dout = entry_reg;

endmodule

// File: sv/rcdf_scan.sv
// rcdf_scan: compares the entry at the ring head against the item, one per cycle.
// Tracks the duplicate hit and the oldest slot. Depends on rcdf_pkg.
`timescale 1ns / 1ps

module rcdf_scan #(
    parameter int IDX_W = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rcdf_pkg::scan_ctl_t          ctl,
    input  logic [IDX_W-1:0]             step,
    input  rcdf_pkg::entry_t             head,
    input  logic [rcdf_pkg::CODE_W-1:0]  code,
    input  logic [rcdf_pkg::STAMP_W-1:0] now,
    input  logic [31:0]                  window,
    output logic                         hit,
    output logic [IDX_W-1:0]             best_idx
);
    import rcdf_pkg::*;

    logic               hit_reg, hit_next;
    logic [STAMP_W-1:0] best_stamp_reg, best_stamp_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [STAMP_W-1:0] age;
    logic               match;
    logic               older;

    // Per-entry compare: age is modulo 2^32
    always_comb
    begin
        age   = now - head.stamp;
        match = (head.code == code) && (age < window);
        older = ctl.first || (head.stamp < best_stamp_reg);

        hit_next        = hit_reg;
        best_stamp_next = best_stamp_reg;
        best_idx_next   = best_idx_reg;
        if (ctl.scan_en)
        begin
            hit_next = (ctl.first ? 1'b0 : hit_reg) | match;
            if (older)
            begin
                best_stamp_next = head.stamp;
                best_idx_next   = step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg        <= 1'b0;
            best_stamp_reg <= '0;
            best_idx_reg   <= '0;
        end
        else
        begin
            hit_reg        <= hit_next;
            best_stamp_reg <= best_stamp_next;
            best_idx_reg   <= best_idx_next;
        end
    end

    assign hit      = hit_reg;
    assign best_idx = best_idx_reg;

endmodule
